@@ hw/rtl/i2ra_pkg.sv @@
// Shared types, sizes and character codes for the integer to radix ASCII core.
// Used by the controller, the datapath, the top level and the checker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2ra_pkg;

	// Width of the numeric value that is converted (low bits of the value port)
	localparam int VALUE_BITS = 64;
	// Width of the value port as fixed by the interface
	localparam int IN_BITS = 64;

	// Digit counts per radix
	localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
	localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
	localparam int DEC_DIGITS = (VALUE_BITS * 3) / 10 + 1;
	localparam int MAX_HO     = (HEX_DIGITS > OCT_DIGITS) ? HEX_DIGITS : OCT_DIGITS;
	localparam int MAX_DIGITS = (MAX_HO > DEC_DIGITS) ? MAX_HO : DEC_DIGITS;
	localparam int DIG_BITS   = MAX_DIGITS * 4;
	localparam int HEX_PAD    = HEX_DIGITS * 4;
	localparam int OCT_PAD    = OCT_DIGITS * 3;
	localparam int IDX_W      = $clog2(MAX_DIGITS);

	// Binary to BCD: bits shifted in per cycle
	localparam int DABBLE_BITS = 4;
	localparam int CONV_STEPS  = (VALUE_BITS + DABBLE_BITS - 1) / DABBLE_BITS;
	localparam int PAD_BITS    = CONV_STEPS * DABBLE_BITS;
	localparam int CNT_W       = (CONV_STEPS > 1) ? $clog2(CONV_STEPS) : 1;

	// Mode codes
	localparam logic [2:0] MODE_HEX_LO = 3'd0;
	localparam logic [2:0] MODE_HEX_UP = 3'd1;
	localparam logic [2:0] MODE_UDEC   = 3'd2;
	localparam logic [2:0] MODE_SDEC   = 3'd3;
	localparam logic [2:0] MODE_OCT    = 3'd4;

	// Character codes
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic dabble;
		logic scan;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic neg;
		logic idx_zero;
		logic out_free;
	} sts_t;

	// ASCII code of one digit 0..15
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] alpha;
		alpha = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
		if (d >= 4'd10) begin
			return alpha + {4'b0000, d} - 8'd10;
		end
		return CHAR_ZERO + {4'b0000, d};
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/integer_to_radix_ascii_core.sv @@
// Top level of the integer to radix ASCII core.
// Joins i2ra_ctrl and i2ra_dpath; depends on i2ra_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall, mode, value): one item is a number and
//   a mode (hex lower, hex upper, unsigned decimal, signed decimal, octal).
//   Items with an unused mode are taken and dropped without output.
//   Output channel (out_valid / out_stall, character, last): one ASCII
//   character per item, most significant digit first, no leading zeros,
//   a '-' first for negative signed decimal; last marks the final character.
//   Sequencing: one input item is handled at a time. After acceptance the
//   core scans for the leading digit, then emits the characters through the
//   output register; decimal items first pass the BCD converter, which
//   shifts 4 bits of the 64-bit value per cycle.
//   A stall on the output holds the current character and pauses emission;
//   the input stays stalled until the final character is in the output
//   register, and the next item may be taken while it waits there.
//   Reset (arst_n low) returns to idle and clears out_valid.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_ascii_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [2:0]                   mode,
	input  wire logic [i2ra_pkg::IN_BITS-1:0] value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [7:0]                        character,
	output logic                              last
);

	i2ra_pkg::cmd_t cmd;
	i2ra_pkg::sts_t sts;

	i2ra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	i2ra_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.mode      (mode),
		.value     (value),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire

@@ hw/rtl/i2ra_ctrl.sv @@
// Controller state machine of the integer to radix ASCII core.
// Sequences load, BCD conversion, digit scan and character emission.
// Depends on i2ra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2ra_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [2:0]    mode,
	input  i2ra_pkg::sts_t     sts,
	output logic               in_stall,
	output i2ra_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]                 state_q, state_d;
	logic [i2ra_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic                       mode_ok, mode_dec;

	// Decode the incoming mode
	always_comb begin
		mode_ok  = mode inside {i2ra_pkg::MODE_HEX_LO, i2ra_pkg::MODE_HEX_UP,
			i2ra_pkg::MODE_UDEC, i2ra_pkg::MODE_SDEC, i2ra_pkg::MODE_OCT};
		mode_dec = mode inside {i2ra_pkg::MODE_UDEC, i2ra_pkg::MODE_SDEC};
	end

	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				// drop items with an unused mode
				if (in_valid && mode_ok) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = mode_dec ? ST_CONV : ST_SCAN;
				end
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == i2ra_pkg::CNT_W'(i2ra_pkg::CONV_STEPS - 1)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = sts.neg ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_digit = 1'b1;
					if (sts.idx_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/i2ra_dpath.sv @@
// Datapath of the integer to radix ASCII core: magnitude and digit registers,
// shift-add-3 BCD converter, leading digit scan and the output register.
// Depends on i2ra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2ra_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  i2ra_pkg::cmd_t                     cmd,
	input  wire logic [2:0]                    mode,
	input  wire logic [i2ra_pkg::IN_BITS-1:0]  value,
	output i2ra_pkg::sts_t                     sts,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic [7:0]                         character,
	output logic                               last
);

	logic [i2ra_pkg::PAD_BITS-1:0]   mag_q;
	logic [i2ra_pkg::DIG_BITS-1:0]   dig_q;
	logic                            neg_q;
	logic                            upper_q;
	logic [i2ra_pkg::IDX_W-1:0]      idx_q;
	logic                            out_valid_q;
	logic [7:0]                      char_q;
	logic                            last_q;

	logic [i2ra_pkg::VALUE_BITS-1:0] val;
	logic                            neg_w;
	logic [i2ra_pkg::VALUE_BITS-1:0] mag_w;
	logic [i2ra_pkg::HEX_PAD-1:0]    hex_src;
	logic [i2ra_pkg::OCT_PAD-1:0]    oct_src;
	logic [i2ra_pkg::DIG_BITS-1:0]   load_dig;
	logic [i2ra_pkg::DIG_BITS-1:0]   dab_dig;
	logic [i2ra_pkg::PAD_BITS-1:0]   dab_mag;
	logic [i2ra_pkg::IDX_W-1:0]      top_idx;
	logic [3:0]                      cur_digit;
	logic                            out_free;

	// Mask the value and take the magnitude of a negative signed value
	always_comb begin
		val     = value[i2ra_pkg::VALUE_BITS-1:0];
		neg_w   = (mode == i2ra_pkg::MODE_SDEC) && val[i2ra_pkg::VALUE_BITS-1];
		mag_w   = neg_w ? (~val + 1'b1) : val;
		hex_src = i2ra_pkg::HEX_PAD'(val);
		oct_src = i2ra_pkg::OCT_PAD'(val);
	end

	// Split hex and octal values straight into digit slots
	always_comb begin
		load_dig = '0;
		if (mode == i2ra_pkg::MODE_OCT) begin
			for (int i = 0; i < i2ra_pkg::OCT_DIGITS; i++) begin
				load_dig[i*4 +: 4] = {1'b0, oct_src[i*3 +: 3]};
			end
		end else if (mode == i2ra_pkg::MODE_HEX_LO || mode == i2ra_pkg::MODE_HEX_UP) begin
			for (int i = 0; i < i2ra_pkg::HEX_DIGITS; i++) begin
				load_dig[i*4 +: 4] = hex_src[i*4 +: 4];
			end
		end
	end

	// Shift-add-3 conversion, several bits per cycle
	always_comb begin
		dab_dig = dig_q;
		dab_mag = mag_q;
		for (int k = 0; k < i2ra_pkg::DABBLE_BITS; k++) begin
			for (int j = 0; j < i2ra_pkg::DEC_DIGITS; j++) begin
				if (dab_dig[j*4 +: 4] >= 4'd5) begin
					dab_dig[j*4 +: 4] = dab_dig[j*4 +: 4] + 4'd3;
				end
			end
			dab_dig = {dab_dig[i2ra_pkg::DIG_BITS-2:0], dab_mag[i2ra_pkg::PAD_BITS-1]};
			dab_mag = {dab_mag[i2ra_pkg::PAD_BITS-2:0], 1'b0};
		end
	end

	// Find the most significant nonzero digit
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < i2ra_pkg::MAX_DIGITS; i++) begin
			if (dig_q[i*4 +: 4] != 4'd0) begin
				top_idx = i2ra_pkg::IDX_W'(i);
			end
		end
	end

	assign cur_digit = dig_q[idx_q*4 +: 4];
	assign out_free  = !out_valid_q || !out_stall;

	assign sts.neg      = neg_q;
	assign sts.idx_zero = (idx_q == '0);
	assign sts.out_free = out_free;

	// Hold working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q   <= i2ra_pkg::PAD_BITS'(mag_w);
			dig_q   <= load_dig;
			neg_q   <= neg_w;
			upper_q <= (mode == i2ra_pkg::MODE_HEX_UP);
		end else if (cmd.dabble) begin
			mag_q <= dab_mag;
			dig_q <= dab_dig;
		end
		if (cmd.scan) begin
			idx_q <= top_idx;
		end else if (cmd.emit_digit) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= i2ra_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= i2ra_pkg::digit_char(cur_digit, upper_q);
			last_q <= (idx_q == '0);
		end
	end

	// Output valid: set on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/i2ra_chk.sv @@
// Port-level checker for the integer to radix ASCII core, bound to the top level.
// Watches only the top level ports. Depends on i2ra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2ra_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [2:0]  mode,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  character,
	input wire logic        last
);

	// Hold a stalled character
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(character) && $stable(last))
		else $error("stalled output item changed");

	// Go busy after taking an item with a used mode
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (mode <= i2ra_pkg::MODE_OCT) |=> in_stall)
		else $error("input not stalled while converting");

	// Minus sign never ends a run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (character == i2ra_pkg::CHAR_MINUS) |-> !last)
		else $error("run ends on a minus sign");

	// Only digits, hex letters and minus appear
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((character >= i2ra_pkg::CHAR_ZERO)
				&& (character <= i2ra_pkg::CHAR_ZERO + 8'd9))
			|| ((character >= i2ra_pkg::CHAR_LOWER_A)
				&& (character <= i2ra_pkg::CHAR_LOWER_A + 8'd5))
			|| ((character >= i2ra_pkg::CHAR_UPPER_A)
				&& (character <= i2ra_pkg::CHAR_UPPER_A + 8'd5))
			|| (character == i2ra_pkg::CHAR_MINUS))
		else $error("unexpected output character");

endmodule

bind integer_to_radix_ascii_core i2ra_chk u_i2ra_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.mode      (mode),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.character (character),
	.last      (last)
);

`default_nettype wire
